// ===== rtl/compressor_level_detector_unit_assert.svh =====
// Assertion macros for the level detector.
`ifndef COMPRESSOR_LEVEL_DETECTOR_UNIT_ASSERT_SVH
`define COMPRESSOR_LEVEL_DETECTOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CLD_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define CLD_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define CLD_ASSERT_IMP(label, a, c)
`define CLD_ASSERT_NEXT(label, a, c)
`endif
`endif

// ===== rtl/cld_pkg.sv =====
package cld_pkg;
  localparam int ChannelsDefault = 2;
  localparam int KeyW = 24;
  localparam int EnvW = 23;
  localparam int MsW = 32;
  localparam int CoefW = 16;
  localparam int LinkW = 17;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 17;
  localparam logic [EnvW-1:0] EnvMax = {EnvW{1'b1}};
  localparam logic [MsW-1:0] MsMax = {MsW{1'b1}};
  localparam logic [LinkW-1:0] LinkFull = 17'h10000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DETECT_LAW = 3'd0, REG_RMS_COEF = 3'd1, REG_LINK = 3'd2, REG_ATTACK = 3'd3,
    REG_RELEASE = 3'd4, REG_AUTO_REL = 3'd5, REG_SLOW_CHARGE = 3'd6, REG_SLOW_RELEASE = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAG, ST_MS_A, ST_MS_B, ST_MS_C, ST_SQRT, ST_SQRT_END,
    ST_NEXT_MAG, ST_LINK, ST_FAST, ST_SLOW, ST_NEXT_FOL, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mag;
    logic ms_a;
    logic ms_b;
    logic ms_c;
    logic sqrt_start;
    logic sqrt_step;
    logic sqrt_end;
    logic do_link;
    logic fast;
    logic slow;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rms;
    logic sqrt_done;
    logic link_on;
    logic auto_rel;
  } sts_t;
endpackage

// ===== rtl/cld_ctrl.sv =====
module cld_ctrl #(
  parameter int Channels = cld_pkg::ChannelsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_count,
  input  logic out_free,
  input  cld_pkg::sts_t sts,
  output cld_pkg::cmd_t cmd,
  output logic ch
);
  import cld_pkg::*;

  state_t state, state_next;
  logic [1:0] active, active_next;
  logic ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active <= '0;
      ch <= 1'b0;
    end else begin
      state <= state_next;
      active <= active_next;
      ch <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    active_next = active;
    ch_next = ch;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          ch_next = 1'b0;
          active_next = (in_count > 2'(Channels)) ? 2'(Channels) : in_count;
          state_next = (active_next == 2'd0) ? ST_OUT : ST_MAG;
        end
      end
      ST_MAG: begin
        cmd.mag = 1'b1;
        state_next = sts.rms ? ST_MS_A : ST_NEXT_MAG;
      end
      ST_MS_A: begin cmd.ms_a = 1'b1; state_next = ST_MS_B; end
      ST_MS_B: begin cmd.ms_b = 1'b1; state_next = ST_MS_C; end
      ST_MS_C: begin cmd.ms_c = 1'b1; state_next = ST_SQRT; cmd.sqrt_start = 1'b1; end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) state_next = ST_SQRT_END;
      end
      ST_SQRT_END: begin cmd.sqrt_end = 1'b1; state_next = ST_NEXT_MAG; end
      ST_NEXT_MAG: begin
        if ({1'b0, ch} + 2'd1 < active) begin
          ch_next = 1'b1;
          state_next = ST_MAG;
        end else begin
          ch_next = 1'b0;
          state_next = (sts.link_on && active > 2'd1) ? ST_LINK : ST_FAST;
        end
      end
      ST_LINK: begin
        cmd.do_link = 1'b1;
        if (ch) begin
          ch_next = 1'b0;
          state_next = ST_FAST;
        end else begin
          ch_next = 1'b1;
        end
      end
      ST_FAST: begin
        cmd.fast = 1'b1;
        state_next = sts.auto_rel ? ST_SLOW : ST_NEXT_FOL;
      end
      ST_SLOW: begin cmd.slow = 1'b1; state_next = ST_NEXT_FOL; end
      ST_NEXT_FOL: begin
        if ({1'b0, ch} + 2'd1 < active) begin
          ch_next = 1'b1;
          state_next = ST_FAST;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `include "compressor_level_detector_unit_assert.svh"
  `CLD_ASSERT_IMP(a_ready_idle, in_ready, state == ST_IDLE)
  `CLD_ASSERT_NEXT(a_load_leaves, cmd.load, state != ST_IDLE)
  `CLD_ASSERT_IMP(a_active_range, state != ST_IDLE, active <= 2'(Channels))
endmodule

// ===== rtl/cld_datapath.sv =====
module cld_datapath #(
  parameter int Channels = cld_pkg::ChannelsDefault
) (
  input  logic clk,
  input  logic rst,
  input  cld_pkg::cmd_t cmd,
  input  logic ch,
  output cld_pkg::sts_t sts,
  input  logic signed [cld_pkg::KeyW-1:0] key_ch0,
  input  logic signed [cld_pkg::KeyW-1:0] key_ch1,
  input  logic [1:0] in_count,
  input  logic cfg_valid,
  input  logic [cld_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [cld_pkg::CfgDataW-1:0] cfg_data,
  output logic [cld_pkg::EnvW-1:0] env0,
  output logic [cld_pkg::EnvW-1:0] env1
);
  import cld_pkg::*;

  logic detect_law, auto_rel;
  logic [CoefW-1:0] rms_coef, attack_coef, release_coef, slow_charge, slow_release;
  logic [LinkW-1:0] link_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_law <= 1'b0; rms_coef <= '0; link_amount <= '0; attack_coef <= '0;
      release_coef <= '0; auto_rel <= 1'b0; slow_charge <= '0; slow_release <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DETECT_LAW:   detect_law <= cfg_data[0];
        REG_RMS_COEF:     rms_coef <= cfg_data[CoefW-1:0];
        REG_LINK:         link_amount <= cfg_data[LinkW-1:0];
        REG_ATTACK:       attack_coef <= cfg_data[CoefW-1:0];
        REG_RELEASE:      release_coef <= cfg_data[CoefW-1:0];
        REG_AUTO_REL:     auto_rel <= cfg_data[0];
        REG_SLOW_CHARGE:  slow_charge <= cfg_data[CoefW-1:0];
        REG_SLOW_RELEASE: slow_release <= cfg_data[CoefW-1:0];
        default: ;
      endcase
    end
  end

  logic [LinkW-1:0] link;
  assign link = (link_amount > LinkFull) ? LinkFull : link_amount;
  assign sts.rms = detect_law;
  assign sts.link_on = link != '0;
  assign sts.auto_rel = auto_rel;

  logic [MsW-1:0] ms [Channels];
  logic [EnvW-1:0] fast_env [Channels];
  logic [EnvW-1:0] slow_env [Channels];
  logic [EnvW-1:0] mag [2];
  logic [EnvW-1:0] fast_res [2];
  logic signed [KeyW-1:0] key [2];
  logic [1:0] count_q;
  logic [KeyW-1:0] absv;
  logic [47:0] sq_full;
  logic [MsW-1:0] sq;
  logic [49:0] acc;
  logic [EnvW-1:0] other;
  logic [EnvW-1:0] mx;
  logic [EnvW-1:0] x, y, d, fol_new;
  logic [CoefW-1:0] fc;
  logic [39:0] prod;
  logic [EnvW:0] linked;

  // channel index into state arrays
  logic cs;
  assign cs = (Channels > 1) ? ch : 1'b0;

  assign absv = key[ch][KeyW-1] ? KeyW'(-key[ch]) : key[ch];

  // shared multiplier, one product per cycle
  logic [23:0] mul_a;
  logic [31:0] mul_b;
  logic [55:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // isqrt unit: one result bit per cycle on ms << 14
  logic [45:0] rad;
  logic [47:0] rem;
  logic [23:0] root;
  logic [4:0] sq_cnt;
  logic [47:0] trial;
  assign sts.sqrt_done = sq_cnt == 5'd0;
  assign trial = {rem[45:0], rad[45:44]} - {22'd0, root, 2'b01};

  assign mx = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign other = mx - mag[ch];

  // follower
  assign x = mag[ch];
  assign y = cmd.slow ? slow_env[cs] : fast_env[cs];
  assign fc = cmd.slow ? ((x > y) ? slow_charge : slow_release)
                       : ((x > y) ? attack_coef : release_coef);
  assign d = (y >= x) ? (y - x) : (x - y);
  assign prod = fc * d + 40'd32768;
  assign fol_new = (y >= x) ? (x + prod[38:16]) : (x - prod[38:16]);
  assign linked = {1'b0, mag[ch]} + 24'(({23'd0, link} * {17'd0, other} + 40'd32768) >> 16);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mag) begin
      mul_a = absv;
      mul_b = 32'(absv);
    end else if (cmd.ms_a) begin
      mul_a = 24'(rms_coef);
      mul_b = ms[cs];
    end else begin
      mul_a = 24'(17'h10000 - {1'b0, rms_coef});
      mul_b = sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Channels; i++) begin
        ms[i] <= '0; fast_env[i] <= '0; slow_env[i] <= '0;
      end
      sq_cnt <= '0;
    end else begin
      if (cmd.load) begin
        key[0] <= key_ch0; key[1] <= key_ch1; count_q <= in_count;
        mag[0] <= '0; mag[1] <= '0; fast_res[0] <= '0; fast_res[1] <= '0;
      end
      if (cmd.mag) begin
        sq_full <= mul_p[47:0];
        mag[ch] <= (absv > 24'(EnvMax)) ? EnvMax : absv[EnvW-1:0];
      end
      if (cmd.ms_a) begin
        sq <= (sq_full[47:14] > 34'(MsMax)) ? MsMax : sq_full[45:14];
        acc <= 50'(mul_p) + 50'd32768;
      end
      if (cmd.ms_b) acc <= acc + 50'(mul_p);
      if (cmd.ms_c) begin
        ms[cs] <= (acc[49:16] > 34'(MsMax)) ? MsMax : acc[47:16];
      end
      // 46-bit radicand: 23 bit pairs, one step each
      if (cmd.sqrt_start) begin
        rad <= {((acc[49:16] > 34'(MsMax)) ? MsMax : acc[47:16]), 14'd0};
        rem <= '0; root <= '0; sq_cnt <= 5'd22;
      end else if (cmd.sqrt_step) begin
        rad <= {rad[43:0], 2'b00};
        if (!trial[47]) begin
          rem <= trial; root <= {root[22:0], 1'b1};
        end else begin
          rem <= {rem[45:0], rad[45:44]}; root <= {root[22:0], 1'b0};
        end
        if (sq_cnt != 5'd0) sq_cnt <= sq_cnt - 5'd1;
      end
      if (cmd.sqrt_end) mag[ch] <= (root > 24'(EnvMax)) ? EnvMax : root[EnvW-1:0];
      if (cmd.do_link) mag[ch] <= linked[EnvW] ? EnvMax : linked[EnvW-1:0];
      if (cmd.fast) begin
        fast_env[cs] <= fol_new;
        fast_res[ch] <= fol_new;
        mag[ch] <= auto_rel ? x : fol_new;
      end
      if (cmd.slow) begin
        slow_env[cs] <= fol_new;
        mag[ch] <= (fast_res[ch] > fol_new) ? fast_res[ch] : fol_new;
      end
    end
  end

  // the multiplier result of the sqrt-start (ms_c) cycle is unused; ms_b finishes the sum and ms_c stores it
  assign env0 = mag[0];
  assign env1 = (count_q > 2'd1 && Channels > 1) ? mag[1] : '0;

  `include "compressor_level_detector_unit_assert.svh"
  `CLD_ASSERT_NEXT(a_sqrt_load, cmd.sqrt_start, sq_cnt == 5'd22)
  `CLD_ASSERT_IMP(a_sqrt_busy, cmd.sqrt_step && !cmd.sqrt_start, detect_law)
endmodule

// ===== rtl/compressor_level_detector_unit.sv =====
// Level detector for a dynamics processor: takes one frame of up to two key
// samples and returns one envelope per channel (peak or RMS magnitude, stereo
// link, attack/release follower, optional slow auto-release follower). A frame
// is accepted, then each channel's magnitude is found, in RMS mode with the
// 23-step bit-serial square root and the shared 24x32 multiplier, then the
// followers run and the result is written to the output register. The
// next frame is taken once the result register has been loaded.
module compressor_level_detector_unit #(
  parameter int Channels = cld_pkg::ChannelsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // key_ch0, key_ch1, channel_count
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [47:0] m_axis_tdata,   // env_ch0, env_ch1
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [cld_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [cld_pkg::CfgDataW-1:0] cfg_data
);
  import cld_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic ch, in_ready, out_free;
  logic [EnvW-1:0] env0, env1;
  logic [47:0] out_data;

  assign cfg_ready = 1'b1;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = in_ready;

  cld_ctrl #(.Channels(Channels)) u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready,
    .in_count(s_axis_tdata[49:48]), .out_free, .sts, .cmd, .ch
  );

  cld_datapath #(.Channels(Channels)) u_dp (
    .clk, .rst, .cmd, .ch, .sts,
    .key_ch0(s_axis_tdata[23:0]), .key_ch1(s_axis_tdata[47:24]),
    .in_count(s_axis_tdata[49:48]),
    .cfg_valid, .cfg_index, .cfg_data, .env0, .env1
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= {2'b00, env1, env0};
  end
  assign m_axis_tdata = out_data;

  `include "compressor_level_detector_unit_assert.svh"
  `CLD_ASSERT_IMP(a_out_hold, m_axis_tvalid && !m_axis_tready, !cmd.out_load)
endmodule
